// File: rtl/core/gssi_pkg.sv
// ----------------------------------------------------------------------------
// gssi_pkg: shared constants for the generational handle table
// Field widths, action codes and status codes used by the interfaces and core.
// ----------------------------------------------------------------------------
package gssi_pkg;

  localparam int unsigned IDX_W    = 10;  // entity index / position width
  localparam int unsigned GEN_IN_W = 16;  // generation field width at the ports
  localparam int unsigned LIVE_W   = 11;  // live entry count width
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned ST_W     = 2;

  localparam logic [ACT_W-1:0] ACT_NEW_ID   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_GET_CRT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SET_GEN  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ID_AT    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd6;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

endpackage

// File: rtl/core/gssi_if.sv
// ----------------------------------------------------------------------------
// gssi_req_if / gssi_rsp_if: request and response channels
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface gssi_req_if;
  logic                                valid;
  logic                                ready;
  logic [gssi_pkg::ACT_W-1:0]          action;
  logic [gssi_pkg::IDX_W-1:0]          index;
  logic [gssi_pkg::GEN_IN_W-1:0]       generation;
  logic [gssi_pkg::IDX_W-1:0]          position;

  modport source (output valid, action, index, generation, position, input ready);
  modport sink   (input valid, action, index, generation, position, output ready);
endinterface

interface gssi_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [gssi_pkg::ST_W-1:0]           status;
  logic [gssi_pkg::IDX_W-1:0]          out_index;
  logic [gssi_pkg::GEN_IN_W-1:0]       out_generation;
  logic                                alive;
  logic                                exists;
  logic [gssi_pkg::LIVE_W-1:0]         live_entries;

  modport source (output valid, status, out_index, out_generation, alive, exists,
                  live_entries, input ready);
  modport sink   (input valid, status, out_index, out_generation, alive, exists,
                  live_entries, output ready);
endinterface

// File: rtl/core/generational_sparse_set_ids_core.sv
// Generational handle table. One request transaction performs one action (new id,
// acquire, remove, query, set generation, id at position, clear) and gives
// one response transaction. A small sequencer drives one map RAM (index -> dense
// slot) and one slot RAM (slot -> index, generation), each with one registered
// read and one write per cycle. Acquire of a dead entry and remove may add a swap
// of two slot entries (read both, then write both) before the lookup. Clear walks
// the map one entry per cycle over min(INDEX_RANGE,1024) entries. After reset
// the same map walk runs before the first request is accepted. A finished
// response sits in an output register while the next request is accepted.
// ----------------------------------------------------------------------------
// generational_sparse_set_ids_core: handle table top level
// Sequencer, map RAM, slot RAM and response register.
// ----------------------------------------------------------------------------
module generational_sparse_set_ids_core #(
  parameter int unsigned INDEX_RANGE = 1024,
  parameter int unsigned DENSE_SLOTS = 1024,
  parameter int unsigned GEN_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gssi_req_if.sink    req,
  gssi_rsp_if.source  rsp
);
  import gssi_pkg::*;

  // map only needs entries that a 10-bit index can reach
  localparam int unsigned MAPD = (INDEX_RANGE < (1 << IDX_W)) ? INDEX_RANGE : (1 << IDX_W);
  localparam int unsigned MAW  = $clog2(MAPD);
  localparam int unsigned SAW  = $clog2(DENSE_SLOTS + 1);   // slot address
  localparam int unsigned CW   = $clog2(DENSE_SLOTS + 2);   // live/used counters
  localparam int unsigned HW   = IDX_W + GEN_BITS;          // slot entry {idx, gen}

  // sequencer states
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_NI_RD  = 5'd3;
  localparam logic [4:0] S_GC_MAP = 5'd4;
  localparam logic [4:0] S_GC_MV  = 5'd5;
  localparam logic [4:0] S_GC_PUT = 5'd6;
  localparam logic [4:0] S_RM_MAP = 5'd7;
  localparam logic [4:0] S_RM_SLT = 5'd8;
  localparam logic [4:0] S_SG_MAP = 5'd9;
  localparam logic [4:0] S_IA_RD  = 5'd10;
  localparam logic [4:0] S_SW_RA  = 5'd11;
  localparam logic [4:0] S_SW_RB  = 5'd12;
  localparam logic [4:0] S_SW_W1  = 5'd13;
  localparam logic [4:0] S_SW_W2  = 5'd14;
  localparam logic [4:0] S_LK_RM  = 5'd15;
  localparam logic [4:0] S_LK_RS  = 5'd16;
  localparam logic [4:0] S_LK_FIN = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0]          state_q, state_d;
  logic [ACT_W-1:0]    act_q, act_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [GEN_BITS-1:0] gen_q, gen_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [CW-1:0]       lb_q, lb_d;      // live bound
  logic [CW-1:0]       su_q, su_d;      // slots used
  logic [IDX_W-1:0]    hi_q, hi_d;      // highest issued
  logic                none_q, none_d;
  logic [SAW-1:0]      s_q, s_d;
  logic [SAW-1:0]      sa_q, sa_d;
  logic [SAW-1:0]      sb_q, sb_d;
  logic [HW-1:0]       ha_q, ha_d;
  logic [HW-1:0]       hb_q, hb_d;
  logic [MAW-1:0]      cnt_q, cnt_d;
  logic                clr_rsp_q, clr_rsp_d;
  logic                ogslot_q, ogslot_d; // take out generation from stored slot
  logic [ST_W-1:0]     st_q, st_d;
  logic [IDX_W-1:0]    oi_q, oi_d;
  logic [GEN_BITS-1:0] og_q, og_d;
  logic                al_q, al_d;
  logic                ex_q, ex_d;

  // response register
  logic                rv_q, rv_d;
  logic [ST_W-1:0]     rst_q, rst_d;
  logic [IDX_W-1:0]    roi_q, roi_d;
  logic [GEN_IN_W-1:0] rog_q, rog_d;
  logic                ral_q, ral_d;
  logic                rex_q, rex_d;
  logic [LIVE_W-1:0]   rle_q, rle_d;

  // memories
  logic [SAW-1:0] map_mem [MAPD];
  logic [HW-1:0]  slot_mem [DENSE_SLOTS + 1];
  logic           map_we, slot_we;
  logic [MAW-1:0] map_wa, map_ra;
  logic [SAW-1:0] map_wd, map_rd_q;
  logic [SAW-1:0] slot_wa, slot_ra;
  logic [HW-1:0]  slot_wd, slot_rd_q;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[slot_ra];
  end

  // helpers
  logic [IDX_W-1:0]    rd_idx, ha_idx, hb_idx;
  logic [GEN_BITS-1:0] rd_gen;
  logic [LIVE_W-1:0]   cand;
  logic                idx_ok, cand_ok, p1_ok, full;
  logic [LIVE_W-1:0]   p1;
  logic [CW-1:0]       lb_m1;
  logic [GEN_BITS-1:0] gen_in;
  logic                req_acc;

  assign rd_idx  = slot_rd_q[HW-1:GEN_BITS];
  assign rd_gen  = slot_rd_q[GEN_BITS-1:0];
  assign ha_idx  = ha_q[HW-1:GEN_BITS];
  assign hb_idx  = hb_q[HW-1:GEN_BITS];
  assign cand    = none_q ? '0 : ({1'b0, hi_q} + LIVE_W'(1));
  assign idx_ok  = 32'(idx_q) < INDEX_RANGE;
  assign cand_ok = 32'(cand) < INDEX_RANGE;
  assign p1      = {1'b0, pos_q} + LIVE_W'(1);
  assign p1_ok   = 32'(p1) < 32'(lb_q);
  assign full    = su_q > CW'(DENSE_SLOTS);
  assign lb_m1   = lb_q - CW'(1);
  assign gen_in  = GEN_BITS'(req.generation);
  assign req_acc = req.valid && req.ready;

  assign req.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    idx_d     = idx_q;
    gen_d     = gen_q;
    pos_d     = pos_q;
    lb_d      = lb_q;
    su_d      = su_q;
    hi_d      = hi_q;
    none_d    = none_q;
    s_d       = s_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    ha_d      = ha_q;
    hb_d      = hb_q;
    cnt_d     = cnt_q;
    clr_rsp_d = clr_rsp_q;
    ogslot_d  = ogslot_q;
    st_d      = st_q;
    oi_d      = oi_q;
    og_d      = og_q;
    al_d      = al_q;
    ex_d      = ex_q;
    rv_d      = rv_q && !rsp.ready;
    rst_d     = rst_q;
    roi_d     = roi_q;
    rog_d     = rog_q;
    ral_d     = ral_q;
    rex_d     = rex_q;
    rle_d     = rle_q;
    map_we    = 1'b0;
    map_wa    = '0;
    map_wd    = '0;
    map_ra    = '0;
    slot_we   = 1'b0;
    slot_wa   = '0;
    slot_wd   = '0;
    slot_ra   = '0;

    case (state_q)
      S_CLR: begin
        map_we = 1'b1;
        map_wa = cnt_q;
        cnt_d  = cnt_q + MAW'(1);
        if (cnt_q == MAW'(MAPD - 1)) begin
          state_d = clr_rsp_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          act_d    = req.action;
          idx_d    = req.index;
          gen_d    = gen_in;
          pos_d    = req.position;
          st_d     = ST_OK;
          ogslot_d = 1'b0;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        // error response unless an arm below says otherwise
        st_d    = ST_RANGE;
        oi_d    = '0;
        og_d    = '0;
        al_d    = 1'b0;
        ex_d    = 1'b0;
        state_d = S_DONE;
        case (act_q)
          ACT_NEW_ID: begin
            if (lb_q < su_q) begin
              st_d    = ST_OK;
              slot_ra = lb_q[SAW-1:0];
              lb_d    = lb_q + CW'(1);
              state_d = S_NI_RD;
            end else if (!full && cand_ok) begin
              st_d    = ST_OK;
              slot_we = 1'b1;
              slot_wa = su_q[SAW-1:0];
              slot_wd = {cand[IDX_W-1:0], {GEN_BITS{1'b0}}};
              map_we  = 1'b1;
              map_wa  = cand[MAW-1:0];
              map_wd  = su_q[SAW-1:0];
              hi_d    = cand[IDX_W-1:0];
              none_d  = 1'b0;
              lb_d    = lb_q + CW'(1);
              su_d    = su_q + CW'(1);
              oi_d    = cand[IDX_W-1:0];
              state_d = S_LK_RM;
            end
          end
          ACT_GET_CRT: begin
            if (idx_ok) begin
              st_d    = ST_OK;
              map_ra  = idx_q[MAW-1:0];
              state_d = S_GC_MAP;
            end
          end
          ACT_REMOVE: begin
            if (idx_ok) begin
              st_d    = ST_OK;
              oi_d    = idx_q;
              og_d    = gen_q;
              map_ra  = idx_q[MAW-1:0];
              state_d = S_RM_MAP;
            end
          end
          ACT_QUERY: begin
            if (idx_ok) begin
              st_d    = ST_OK;
              oi_d    = idx_q;
              og_d    = gen_q;
              state_d = S_LK_RM;
            end
          end
          ACT_SET_GEN: begin
            if (idx_ok) begin
              st_d    = ST_OK;
              oi_d    = idx_q;
              og_d    = gen_q;
              map_ra  = idx_q[MAW-1:0];
              state_d = S_SG_MAP;
            end
          end
          ACT_ID_AT: begin
            if (p1_ok) begin
              st_d    = ST_OK;
              slot_ra = p1[SAW-1:0];
              state_d = S_IA_RD;
            end
          end
          ACT_CLEAR: begin
            st_d      = ST_OK;
            lb_d      = CW'(1);
            su_d      = CW'(1);
            hi_d      = '0;
            none_d    = 1'b0;
            cnt_d     = '0;
            clr_rsp_d = 1'b1;
            state_d   = S_CLR;
          end
          default: ;
        endcase
      end
      S_NI_RD: begin
        oi_d    = rd_idx;
        og_d    = rd_gen;
        state_d = S_LK_RM;
      end
      S_GC_MAP: begin
        if (map_rd_q != '0) begin
          oi_d     = idx_q;
          ogslot_d = 1'b1;
          state_d  = S_LK_RM;
          if (CW'(map_rd_q) >= lb_q) begin
            lb_d = lb_q + CW'(1);
            sa_d = map_rd_q;
            sb_d = lb_q[SAW-1:0];
            if (CW'(map_rd_q) != lb_q) begin
              state_d = S_SW_RA;
            end
          end
        end else if (full) begin
          st_d    = ST_RANGE;
          oi_d    = '0;
          og_d    = '0;
          al_d    = 1'b0;
          ex_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          sa_d = lb_q[SAW-1:0];   // new live slot
          sb_d = su_q[SAW-1:0];   // top of used region
          su_d = su_q + CW'(1);
          lb_d = lb_q + CW'(1);
          if (none_q || idx_q >= hi_q) begin
            hi_d   = idx_q;
            none_d = 1'b0;
          end
          oi_d = idx_q;
          og_d = gen_q;
          if (lb_q < su_q) begin
            slot_ra = lb_q[SAW-1:0];
            state_d = S_GC_MV;
          end else begin
            state_d = S_GC_PUT;
          end
        end
      end
      S_GC_MV: begin
        // first dead slot moves to the top
        slot_we = 1'b1;
        slot_wa = sb_q;
        slot_wd = slot_rd_q;
        map_we  = 32'(rd_idx) < INDEX_RANGE;
        map_wa  = rd_idx[MAW-1:0];
        map_wd  = sb_q;
        state_d = S_GC_PUT;
      end
      S_GC_PUT: begin
        map_we  = 1'b1;
        map_wa  = idx_q[MAW-1:0];
        map_wd  = sa_q;
        slot_we = 1'b1;
        slot_wa = sa_q;
        slot_wd = {idx_q, gen_q};
        state_d = S_LK_RM;
      end
      S_RM_MAP: begin
        if (map_rd_q == '0 || CW'(map_rd_q) >= lb_q) begin
          st_d    = ST_MISMATCH;
          state_d = S_LK_RM;
        end else begin
          s_d     = map_rd_q;
          slot_ra = map_rd_q;
          state_d = S_RM_SLT;
        end
      end
      S_RM_SLT: begin
        if (rd_gen != gen_q) begin
          st_d    = ST_MISMATCH;
          state_d = S_LK_RM;
        end else begin
          slot_we = 1'b1;
          slot_wa = s_q;
          slot_wd = {rd_idx, gen_q + GEN_BITS'(1)};
          og_d    = gen_q + GEN_BITS'(1);
          sa_d    = s_q;
          sb_d    = lb_m1[SAW-1:0];
          lb_d    = lb_m1;
          state_d = (CW'(s_q) != lb_m1) ? S_SW_RA : S_LK_RM;
        end
      end
      S_SG_MAP: begin
        if (map_rd_q != '0) begin
          slot_we = 1'b1;
          slot_wa = map_rd_q;
          slot_wd = {idx_q, gen_q};
        end else begin
          st_d = ST_MISMATCH;
        end
        state_d = S_LK_RM;
      end
      S_IA_RD: begin
        oi_d    = rd_idx;
        og_d    = rd_gen;
        state_d = S_LK_RM;
      end
      S_SW_RA: begin
        slot_ra = sa_q;
        state_d = S_SW_RB;
      end
      S_SW_RB: begin
        ha_d    = slot_rd_q;
        slot_ra = sb_q;
        state_d = S_SW_W1;
      end
      S_SW_W1: begin
        hb_d    = slot_rd_q;
        slot_we = 1'b1;
        slot_wa = sb_q;
        slot_wd = ha_q;
        map_we  = 32'(ha_idx) < INDEX_RANGE;
        map_wa  = ha_idx[MAW-1:0];
        map_wd  = sb_q;
        state_d = S_SW_W2;
      end
      S_SW_W2: begin
        slot_we = 1'b1;
        slot_wa = sa_q;
        slot_wd = hb_q;
        map_we  = 32'(hb_idx) < INDEX_RANGE;
        map_wa  = hb_idx[MAW-1:0];
        map_wd  = sa_q;
        state_d = S_LK_RM;
      end
      S_LK_RM: begin
        map_ra  = oi_q[MAW-1:0];
        state_d = S_LK_RS;
      end
      S_LK_RS: begin
        s_d     = (32'(oi_q) < INDEX_RANGE) ? map_rd_q : '0;
        slot_ra = s_d;
        state_d = S_LK_FIN;
      end
      S_LK_FIN: begin
        ex_d = (s_q != '0) && (CW'(s_q) < lb_q);
        if (ogslot_q) begin
          og_d = rd_gen;
          al_d = ex_d;
        end else begin
          al_d = ex_d && (rd_gen == og_q);
        end
        if (act_q == ACT_QUERY) begin
          st_d = al_d ? ST_OK : ST_MISMATCH;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rv_q || rsp.ready) begin
          rv_d      = 1'b1;
          rst_d     = st_q;
          roi_d     = clr_rsp_q ? '0 : oi_q;
          rog_d     = clr_rsp_q ? '0 : GEN_IN_W'(og_q);
          ral_d     = clr_rsp_q ? 1'b0 : al_q;
          rex_d     = clr_rsp_q ? 1'b0 : ex_q;
          rle_d     = LIVE_W'(lb_m1);
          clr_rsp_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      lb_q      <= CW'(1);
      su_q      <= CW'(1);
      hi_q      <= '0;
      none_q    <= 1'b1;
      cnt_q     <= '0;
      clr_rsp_q <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      lb_q      <= lb_d;
      su_q      <= su_d;
      hi_q      <= hi_d;
      none_q    <= none_d;
      cnt_q     <= cnt_d;
      clr_rsp_q <= clr_rsp_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    idx_q    <= idx_d;
    gen_q    <= gen_d;
    pos_q    <= pos_d;
    s_q      <= s_d;
    sa_q     <= sa_d;
    sb_q     <= sb_d;
    ha_q     <= ha_d;
    hb_q     <= hb_d;
    ogslot_q <= ogslot_d;
    st_q     <= st_d;
    oi_q     <= oi_d;
    og_q     <= og_d;
    al_q     <= al_d;
    ex_q     <= ex_d;
    rst_q    <= rst_d;
    roi_q    <= roi_d;
    rog_q    <= rog_d;
    ral_q    <= ral_d;
    rex_q    <= rex_d;
    rle_q    <= rle_d;
  end

  assign rsp.valid          = rv_q;
  assign rsp.status         = rst_q;
  assign rsp.out_index      = roi_q;
  assign rsp.out_generation = rog_q;
  assign rsp.alive          = ral_q;
  assign rsp.exists         = rex_q;
  assign rsp.live_entries   = rle_q;

`ifndef SYNTHESIS
  // live region never passes the used region
  a_live_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lb_q <= su_q) else $error("live bound above slots used");

  // used region stays within the dense store
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    su_q <= CW'(DENSE_SLOTS + 1)) else $error("slots used out of range");

  // a pending response is never overwritten before it is taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && !rsp.ready) |=> (rv_q && $stable(rst_q) && $stable(roi_q)))
    else $error("response lost");
`endif

endmodule
